// ----- rtl/mecanum_wheel_mixer_defines.svh -----
// Assertion macros shared by the mecanum wheel mixer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MECANUM_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_DEFINES_SVH

// The condition must never be true at a clock edge outside reset.
`define MWM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define MWM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/mwm_pkg.sv -----
// Types and constants shared by the mecanum wheel mixer modules.
// No dependencies.
`timescale 1ns / 1ps

package mwm_pkg;

    localparam int unsigned LANES = 4;
    localparam int unsigned DIV_STEPS = 7;

    // Register index decoded from paddr[2].
    localparam logic REG_DZ_LEFT  = 1'b0;
    localparam logic REG_DZ_RIGHT = 1'b1;

    // Wheel sums, magnitudes and the scaled-product numerators.
    typedef struct packed {
        logic [3:0][15:0] prod;
        logic [3:0]       neg;
        logic [3:0][9:0]  wsum;
        logic [8:0]       mag_max;
        logic             big;
    } mwm_mix_t;

    // Quotients of the shrink division along with the raw sums.
    typedef struct packed {
        logic [3:0][6:0] quot;
        logic [3:0]      neg;
        logic [3:0][9:0] wsum;
        logic            big;
    } mwm_div_t;

    // Deadzone configuration.
    typedef struct packed {
        logic [6:0] dz_left;
        logic [6:0] dz_right;
    } mwm_cfg_t;

endpackage

// ----- rtl/mwm_mix.sv -----
// Mixing front end: wheel sums, largest magnitude and shrink numerators.
// Depends on mwm_pkg.
`timescale 1ns / 1ps

module mwm_mix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [7:0]   strafe,
    input  logic signed [7:0]   forward,
    input  logic signed [7:0]   spin,
    output logic                out_valid,
    input  logic                out_stall,
    output mwm_pkg::mwm_mix_t   out_data
);

    logic [1:0]                 vld_reg;
    logic [1:0]                 hold;
    logic signed [3:0][9:0]     wsum_reg;
    logic [3:0][8:0]            mag_reg;
    logic signed [9:0]          xe;
    logic signed [9:0]          ye;
    logic signed [9:0]          ze;
    logic signed [3:0][9:0]     wsum_next;
    logic [3:0][8:0]            mag_next;
    logic [8:0]                 max_lo;
    logic [8:0]                 max_hi;
    logic [8:0]                 max_all;
    mwm_pkg::mwm_mix_t          data_next;
    mwm_pkg::mwm_mix_t          data_reg;

    // A stage holds while it is full and the stage after it holds.
    assign hold[1]  = vld_reg[1] & out_stall;
    assign hold[0]  = vld_reg[0] & hold[1];
    assign in_stall = hold[0];

    // First stage: the four mecanum sums and their magnitudes.
    always_comb
    begin
        xe = signed'({{2{strafe[7]}}, strafe});
        ye = signed'({{2{forward[7]}}, forward});
        ze = signed'({{2{spin[7]}}, spin});
        wsum_next[0] = ye + xe + ze;
        wsum_next[1] = ye - xe + ze;
        wsum_next[2] = ye - xe - ze;
        wsum_next[3] = ye + xe - ze;
        for (int l = 0; l < 4; l++)
        begin
            if (wsum_next[l][9])
                mag_next[l] = 9'(10'd0 - wsum_next[l]);
            else
                mag_next[l] = wsum_next[l][8:0];
        end
    end

    // Second stage: largest magnitude and magnitude * 127.
    always_comb
    begin
        max_lo  = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        max_hi  = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
        max_all = (max_lo > max_hi) ? max_lo : max_hi;
        data_next.mag_max = max_all;
        data_next.big     = (max_all > 9'd127);
        for (int l = 0; l < 4; l++)
        begin
            data_next.prod[l] = {mag_reg[l], 7'b0} - {7'b0, mag_reg[l]};
            data_next.neg[l]  = wsum_reg[l][9];
            data_next.wsum[l] = wsum_reg[l];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (!hold[0])
                vld_reg[0] <= in_valid;
            if (!hold[1])
                vld_reg[1] <= vld_reg[0];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (!hold[0])
        begin
            wsum_reg <= wsum_next;
            mag_reg  <= mag_next;
        end
        if (!hold[1])
            data_reg <= data_next;
    end

    assign out_valid = vld_reg[1];
    assign out_data  = data_reg;

endmodule

// ----- rtl/mwm_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for all four wheels.
// Depends on mwm_pkg and mecanum_wheel_mixer_defines.svh.
`timescale 1ns / 1ps
`include "mecanum_wheel_mixer_defines.svh"

module mwm_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mwm_pkg::mwm_mix_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mwm_pkg::mwm_div_t   out_data
);

    localparam int unsigned STEPS = mwm_pkg::DIV_STEPS;

    logic [STEPS-1:0]                vld_reg;
    logic [STEPS-1:0]                hold;
    logic [STEPS-1:0][3:0][15:0]     r_reg;
    logic [STEPS-1:0][3:0][6:0]      q_reg;
    logic [STEPS-1:0][8:0]           m_reg;
    logic [STEPS-1:0][3:0]           neg_reg;
    logic [STEPS-1:0][3:0][9:0]      w_reg;
    logic [STEPS-1:0]                big_reg;
    logic [STEPS-1:0][3:0][15:0]     r_src;
    logic [STEPS-1:0][3:0][6:0]      q_src;
    logic [STEPS-1:0][8:0]           m_src;
    logic [STEPS-1:0][3:0]           neg_src;
    logic [STEPS-1:0][3:0][9:0]      w_src;
    logic [STEPS-1:0]                big_src;
    logic [STEPS-1:0][3:0][15:0]     r_next;
    logic [STEPS-1:0][3:0][6:0]      q_next;
    logic [STEPS-1:0]                vld_src;

    // Hold chain from the output back to the input.
    always_comb
    begin
        hold[STEPS-1] = vld_reg[STEPS-1] & out_stall;
        for (int k = STEPS - 2; k >= 0; k--)
            hold[k] = vld_reg[k] & hold[k+1];
    end
    assign in_stall = hold[0];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        // Each stage reads the divider input or the stage before it.
        if (k == 0)
        begin : g_first
            assign r_src[k]   = in_data.prod;
            assign q_src[k]   = '0;
            assign m_src[k]   = in_data.mag_max;
            assign neg_src[k] = in_data.neg;
            assign w_src[k]   = in_data.wsum;
            assign big_src[k] = in_data.big;
            assign vld_src[k] = in_valid;
        end
        else
        begin : g_rest
            assign r_src[k]   = r_reg[k-1];
            assign q_src[k]   = q_reg[k-1];
            assign m_src[k]   = m_reg[k-1];
            assign neg_src[k] = neg_reg[k-1];
            assign w_src[k]   = w_reg[k-1];
            assign big_src[k] = big_reg[k-1];
            assign vld_src[k] = vld_reg[k-1];
        end

        // Trial subtraction of the shifted divisor, quotient bit STEPS-1-k.
        always_comb
        begin
            logic [15:0] dsh;
            logic        ge;
            for (int l = 0; l < 4; l++)
            begin
                dsh = 16'(m_src[k]) << (STEPS - 1 - k);
                ge  = (r_src[k][l] >= dsh);
                r_next[k][l] = ge ? (r_src[k][l] - dsh) : r_src[k][l];
                q_next[k][l] = q_src[k][l] | (7'(ge) << (STEPS - 1 - k));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (!hold[k])
                vld_reg[k] <= vld_src[k];
        end

        always_ff @(posedge clk)
        begin
            if (!hold[k])
            begin
                r_reg[k]   <= r_next[k];
                q_reg[k]   <= q_next[k];
                m_reg[k]   <= m_src[k];
                neg_reg[k] <= neg_src[k];
                w_reg[k]   <= w_src[k];
                big_reg[k] <= big_src[k];
            end
        end
    end

    assign out_valid     = vld_reg[STEPS-1];
    assign out_data.quot = q_reg[STEPS-1];
    assign out_data.neg  = neg_reg[STEPS-1];
    assign out_data.wsum = w_reg[STEPS-1];
    assign out_data.big  = big_reg[STEPS-1];

    // After the last step the remainders of wheels 0 and 3 are below the divisor when big is set.
    `MWM_ASSERT_NEVER(a_div_rem, clk, rst_n, vld_reg[STEPS-1] && big_reg[STEPS-1] && ((r_reg[STEPS-1][0] >= 16'(m_reg[STEPS-1])) || (r_reg[STEPS-1][3] >= 16'(m_reg[STEPS-1]))), "divider remainder not below divisor")

endmodule

// ----- rtl/mwm_shape.sv -----
// Output shaping: sign and offset, clamp, left inversion, deadzone stretch.
// Depends on mwm_pkg and mecanum_wheel_mixer_defines.svh.
`timescale 1ns / 1ps
`include "mecanum_wheel_mixer_defines.svh"

module mwm_shape (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mwm_pkg::mwm_div_t   in_data,
    input  mwm_pkg::mwm_cfg_t   cfg,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          pwm_left_front,
    output logic [7:0]          pwm_left_back,
    output logic [7:0]          pwm_right_front,
    output logic [7:0]          pwm_right_back
);

    logic [3:0]             vld_reg;
    logic [3:0]             hold;
    logic [3:0][7:0]        v1_next;
    logic [3:0][7:0]        v1_reg;
    logic [3:0][7:0]        v2_reg;
    logic [3:0]             st2_next;
    logic [3:0]             st2_reg;
    logic [3:0][6:0]        d2_next;
    logic [3:0][6:0]        d2_reg;
    logic [3:0][13:0]       p2_next;
    logic [3:0][13:0]       p2_reg;
    logic [3:0][7:0]        v3_reg;
    logic [3:0]             st3_reg;
    logic [3:0][6:0]        d3_reg;
    logic [3:0][13:0]       p3_reg;
    logic [3:0][6:0]        e3_next;
    logic [3:0][6:0]        e3_reg;
    logic [3:0][13:0]       rem;
    logic [3:0][7:0]        res_next;
    logic [3:0][7:0]        res_reg;

    always_comb
    begin
        hold[3] = vld_reg[3] & out_stall;
        for (int k = 2; k >= 0; k--)
            hold[k] = vld_reg[k] & hold[k+1];
    end
    assign in_stall = hold[0];

    // Stage one: pick scaled or raw sum, offset by 127, clamp, invert left.
    always_comb
    begin
        logic signed [9:0]  s;
        logic signed [10:0] t;
        logic [7:0]         c;
        for (int l = 0; l < 4; l++)
        begin
            if (!in_data.big)
                s = in_data.wsum[l];
            else if (in_data.neg[l])
                s = 10'd0 - {3'b0, in_data.quot[l]};
            else
                s = {3'b0, in_data.quot[l]};
            t = {s[9], s} + 11'sd127;
            if (t[10])
                c = 8'd0;
            else if (t[9:8] != 2'b00)
                c = 8'd255;
            else
                c = t[7:0];
            v1_next[l] = (l < 2) ? ~c : c;
        end
    end

    // Stage two: stretch test and (127 - D) * (v - 127).
    always_comb
    begin
        logic [14:0] p;
        for (int l = 0; l < 4; l++)
        begin
            if (l < 2)
            begin
                st2_next[l] = (v1_reg[l] > 8'd128);
                d2_next[l]  = cfg.dz_left;
            end
            else
            begin
                st2_next[l] = (v1_reg[l] > 8'd127);
                d2_next[l]  = cfg.dz_right;
            end
            p = 15'(7'd127 - d2_next[l]) * 15'(v1_reg[l] - 8'd127);
            p2_next[l] = p[13:0];
        end
    end

    // Stage three: quotient estimate by 127 as (p * 129) >> 14.
    always_comb
    begin
        logic [20:0] pe;
        for (int l = 0; l < 4; l++)
        begin
            pe = {p2_reg[l], 7'b0} + 21'(p2_reg[l]);
            e3_next[l] = pe[20:14];
        end
    end

    // Stage four: correct the estimate, add the offset, clamp and select.
    always_comb
    begin
        logic [7:0] q;
        logic [9:0] sum;
        for (int l = 0; l < 4; l++)
        begin
            rem[l] = p3_reg[l] - ({e3_reg[l], 7'b0} - 14'(e3_reg[l]));
            q      = {1'b0, e3_reg[l]} + 8'(rem[l] >= 14'd127);
            sum    = 10'(d3_reg[l]) + 10'd127 + 10'(q);
            if (!st3_reg[l])
                res_next[l] = v3_reg[l];
            else if (sum > 10'd255)
                res_next[l] = 8'd255;
            else
                res_next[l] = sum[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (!hold[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < 4; k++)
                if (!hold[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[0])
            v1_reg <= v1_next;
        if (!hold[1])
        begin
            v2_reg  <= v1_reg;
            st2_reg <= st2_next;
            d2_reg  <= d2_next;
            p2_reg  <= p2_next;
        end
        if (!hold[2])
        begin
            v3_reg  <= v2_reg;
            st3_reg <= st2_reg;
            d3_reg  <= d2_reg;
            p3_reg  <= p2_reg;
            e3_reg  <= e3_next;
        end
        if (!hold[3])
            res_reg <= res_next;
    end

    assign out_valid       = vld_reg[3];
    assign pwm_left_front  = res_reg[0];
    assign pwm_left_back   = res_reg[1];
    assign pwm_right_front = res_reg[2];
    assign pwm_right_back  = res_reg[3];

    // The reciprocal estimate is never more than one below the true quotient.
    `MWM_ASSERT_NEVER(a_est_err, clk, rst_n, vld_reg[2] && ((st3_reg[0] && (rem[0] >= 14'd254)) || (st3_reg[2] && (rem[2] >= 14'd254))), "deadzone quotient estimate off by more than one")

endmodule

// ----- rtl/mecanum_wheel_mixer.sv -----
// Top level of the mecanum wheel mixer: APB deadzone registers and the pipeline.
// Depends on mwm_pkg, mwm_mix, mwm_div, mwm_shape and the defines header.
//
// Usage:
// One request on the input channel carries strafe, forward and spin
// (signed 8-bit). One request on the output channel returns the four PWM
// bytes, 127 meaning stop on the right wheels and 128 on the left ones.
// A request moves when valid is high and stall low. The pipeline has two
// mixing stages, seven divider stages (one quotient bit per stage for all
// wheels) and four shaping stages. Throughput is one request per cycle unless
// in_stall holds the input; each stage is registered with its own valid bit.
// When the receiver stalls, the last stage holds its result and earlier
// stages keep filling empty slots; in_stall rises only once the pipeline is
// full back to its input.
// Reset empties the pipeline and sets both deadzones to zero.
// The deadzones sit at APB byte addresses 0 (left) and 4 (right); the user must
// write them only while the pipeline is empty, which the block does not enforce.
`timescale 1ns / 1ps
`include "mecanum_wheel_mixer_defines.svh"

module mecanum_wheel_mixer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [7:0]   strafe,
    input  logic signed [7:0]   forward,
    input  logic signed [7:0]   spin,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          pwm_left_front,
    output logic [7:0]          pwm_left_back,
    output logic [7:0]          pwm_right_front,
    output logic [7:0]          pwm_right_back
);

    mwm_pkg::mwm_cfg_t  cfg_reg;
    mwm_pkg::mwm_mix_t  mix_data;
    mwm_pkg::mwm_div_t  div_data;
    logic               mix_valid;
    logic               mix_stall;
    logic               div_valid;
    logic               div_stall;
    logic               wr_en;

    // Configuration registers.
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                mwm_pkg::REG_DZ_LEFT:  cfg_reg.dz_left  <= pwdata[6:0];
                mwm_pkg::REG_DZ_RIGHT: cfg_reg.dz_right <= pwdata[6:0];
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[2])
            mwm_pkg::REG_DZ_LEFT:  prdata = {25'b0, cfg_reg.dz_left};
            mwm_pkg::REG_DZ_RIGHT: prdata = {25'b0, cfg_reg.dz_right};
            default:               prdata = '0;
        endcase
    end

    mwm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .strafe    (strafe),
        .forward   (forward),
        .spin      (spin),
        .out_valid (mix_valid),
        .out_stall (mix_stall),
        .out_data  (mix_data)
    );

    mwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_stall  (mix_stall),
        .in_data   (mix_data),
        .out_valid (div_valid),
        .out_stall (div_stall),
        .out_data  (div_data)
    );

    mwm_shape u_shape (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (div_valid),
        .in_stall        (div_stall),
        .in_data         (div_data),
        .cfg             (cfg_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pwm_left_front  (pwm_left_front),
        .pwm_left_back   (pwm_left_back),
        .pwm_right_front (pwm_right_front),
        .pwm_right_back  (pwm_right_back)
    );

    // The input is held off only when a finished result is waiting.
    `MWM_ASSERT_IMPLY(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a held result")

endmodule
